[rtl/twdp_pkg.sv]
// Shared constants, payload types and stage bundles of the ternary-weight dot product.
`timescale 1ns / 1ps

package twdp_pkg;

	localparam int LANES     = 8;
	localparam int ACC_BITS  = 24;

	localparam int ACT_W     = 64;
	localparam int CODE_W    = 16;
	localparam int ACT_BITS  = 8;
	localparam int CODE_BITS = 2;
	localparam int SCALE_W   = 32;
	localparam int BIAS_W    = 32;
	localparam int DOT_W     = 24;
	localparam int RES_W     = 48;

	// lanes that actually fit inside both packed fields
	localparam int ACT_FIT   = ACT_W / ACT_BITS;
	localparam int CODE_FIT  = CODE_W / CODE_BITS;
	localparam int FIT_MIN   = (ACT_FIT < CODE_FIT) ? ACT_FIT : CODE_FIT;
	localparam int LANES_FIT = (LANES < FIT_MIN) ? LANES : FIT_MIN;

	localparam int TERM_W    = ACT_BITS + 1;
	localparam int ITEM_W    = $clog2(LANES * (1 << (ACT_BITS - 1)) + 1) + 1;
	localparam int SUM_W     = ACC_BITS + 1;
	localparam int PROD_W    = ACC_BITS + SCALE_W + 1;
	localparam int VAL_W     = PROD_W + 1;

	localparam logic [CODE_BITS-1:0] CODE_POS = 2'b01;
	localparam logic [CODE_BITS-1:0] CODE_NEG = 2'b11;

	typedef logic signed [TERM_W-1:0] term_t;

	typedef struct packed {
		logic [ACT_W-1:0]         act_lanes;
		logic [CODE_W-1:0]        weight_codes;
		logic [SCALE_W-1:0]       row_scale;
		logic signed [BIAS_W-1:0] col_bias;
		logic                     last;
	} item_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result_value;
		logic signed [DOT_W-1:0] dot_sum;
		logic                    saturated;
	} result_t;

	// merged lane total and the end-of-row fields
	typedef struct packed {
		logic signed [ITEM_W-1:0] item_sum;
		logic                     last;
		logic [SCALE_W-1:0]       row_scale;
		logic signed [BIAS_W-1:0] col_bias;
	} merge_t;

	// finished accumulator value of one row
	typedef struct packed {
		logic signed [ACC_BITS-1:0] dot;
		logic                       clip;
		logic [SCALE_W-1:0]         row_scale;
		logic signed [BIAS_W-1:0]   col_bias;
	} row_t;

endpackage

[rtl/ternary_weight_dot_product_top.sv]
// Ternary-weight dot product: lane array, accumulator and scaled output.
// Throughput: one request per cycle unless stalled; non-last requests produce no result.
// A row's result passes the merge, accumulator, product and output registers.
// Every stage holds its own valid bit, so a waiting result does not block new requests
// until all stages behind it are full.
// Reset clears the running sum, the clip flag and all valid bits.
`timescale 1ns / 1ps

module ternary_weight_dot_product_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  twdp_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output twdp_pkg::result_t result
);
	import twdp_pkg::*;

	logic   valid_s1;
	merge_t merge_s1;
	logic   free_s2;
	logic   valid_s2;
	row_t   row_s2;
	logic   free_s3;

	twdp_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.free_s2    (free_s2),
		.valid_s1   (valid_s1),
		.merge_s1   (merge_s1)
	);

	twdp_acc u_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.merge_s1 (merge_s1),
		.free_s2  (free_s2),
		.free_s3  (free_s3),
		.valid_s2 (valid_s2),
		.row_s2   (row_s2)
	);

	twdp_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s2     (valid_s2),
		.row_s2       (row_s2),
		.free_s3      (free_s3),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

[rtl/twdp_lane.sv]
// One lane: signed activation times a ternary weight code.
`timescale 1ns / 1ps

module twdp_lane (
	input  logic [twdp_pkg::ACT_BITS-1:0]  act,
	input  logic [twdp_pkg::CODE_BITS-1:0] code,
	output twdp_pkg::term_t                term
);
	import twdp_pkg::*;

	term_t act_ext;

	assign act_ext = TERM_W'($signed(act));

	always_comb begin
		case (code)
			CODE_POS: term = act_ext;
			CODE_NEG: term = -act_ext;
			default:  term = '0;
		endcase
	end

endmodule

[rtl/twdp_merge.sv]
// Lane array, adder tree over the lane terms and the first pipeline register.
`timescale 1ns / 1ps

module twdp_merge (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  twdp_pkg::item_t item,
	output logic            item_stall,
	input  logic            free_s2,
	output logic            valid_s1,
	output twdp_pkg::merge_t merge_s1
);
	import twdp_pkg::*;

	term_t                    terms [LANES];
	logic signed [ITEM_W-1:0] total;
	logic                     free_s1;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		if (i < LANES_FIT) begin : g_fit
			twdp_lane u_lane (
				.act  (item.act_lanes[ACT_BITS*i +: ACT_BITS]),
				.code (item.weight_codes[CODE_BITS*i +: CODE_BITS]),
				.term (terms[i])
			);
		end else begin : g_off
			assign terms[i] = '0;
		end
	end

	always_comb begin
		total = '0;
		for (int i = 0; i < LANES; i++) begin
			total = total + ITEM_W'(terms[i]);
		end
	end

	assign free_s1    = !valid_s1 || free_s2;
	assign item_stall = !free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (free_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s1 && item_valid) begin
			merge_s1.item_sum  <= total;
			merge_s1.last      <= item.last;
			merge_s1.row_scale <= item.row_scale;
			merge_s1.col_bias  <= item.col_bias;
		end
	end

endmodule

[rtl/twdp_acc.sv]
// Saturating running sum; hands the finished row on when the last chunk arrives.
`timescale 1ns / 1ps

module twdp_acc (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  twdp_pkg::merge_t merge_s1,
	output logic             free_s2,
	input  logic             free_s3,
	output logic             valid_s2,
	output twdp_pkg::row_t   row_s2
);
	import twdp_pkg::*;

	localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

	logic signed [ACC_BITS-1:0] acc_q;
	logic                       clip_q;
	logic signed [SUM_W-1:0]    sum;
	logic signed [ACC_BITS-1:0] acc_sat;
	logic                       clip_now;
	logic                       take;

	assign free_s2 = !valid_s2 || free_s3;
	assign take    = valid_s1 && free_s2;

	always_comb begin
		sum      = SUM_W'(acc_q) + SUM_W'(merge_s1.item_sum);
		clip_now = 1'b0;
		acc_sat  = sum[ACC_BITS-1:0];
		if (sum > SUM_W'(ACC_MAX)) begin
			acc_sat  = ACC_MAX;
			clip_now = 1'b1;
		end else if (sum < SUM_W'(ACC_MIN)) begin
			acc_sat  = ACC_MIN;
			clip_now = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			clip_q   <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (free_s2) begin
				valid_s2 <= take && merge_s1.last;
			end
			if (take) begin
				// clear for the next row once the last chunk is folded in
				if (merge_s1.last) begin
					acc_q  <= '0;
					clip_q <= 1'b0;
				end else begin
					acc_q  <= acc_sat;
					clip_q <= clip_q | clip_now;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && merge_s1.last) begin
			row_s2.dot       <= acc_sat;
			row_s2.clip      <= clip_q | clip_now;
			row_s2.row_scale <= merge_s1.row_scale;
			row_s2.col_bias  <= merge_s1.col_bias;
		end
	end

endmodule

[rtl/twdp_scale.sv]
// Row scale multiply, bias add with 48-bit saturation and the output register.
`timescale 1ns / 1ps

module twdp_scale (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s2,
	input  twdp_pkg::row_t    row_s2,
	output logic              free_s3,
	output logic              result_valid,
	input  logic              result_stall,
	output twdp_pkg::result_t result
);
	import twdp_pkg::*;

	localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
	localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

	logic signed [PROD_W-1:0]   prod_s3;
	logic signed [BIAS_W-1:0]   bias_s3;
	logic signed [ACC_BITS-1:0] dot_s3;
	logic                       clip_s3;
	logic                       valid_s3;

	logic signed [PROD_W-1:0]   scale_ext;
	logic signed [VAL_W-1:0]    total;
	logic signed [RES_W-1:0]    total_sat;
	logic                       total_clip;
	logic                       free_out;

	assign free_out  = !result_valid || !result_stall;
	assign free_s3   = !valid_s3 || free_out;
	assign scale_ext = PROD_W'($signed({1'b0, row_s2.row_scale}));

	always_comb begin
		total      = VAL_W'(prod_s3) + VAL_W'(bias_s3);
		total_clip = 1'b0;
		total_sat  = total[RES_W-1:0];
		if (total > VAL_W'(RES_MAX)) begin
			total_sat  = RES_MAX;
			total_clip = 1'b1;
		end else if (total < VAL_W'(RES_MIN)) begin
			total_sat  = RES_MIN;
			total_clip = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (free_s3) begin
				valid_s3 <= valid_s2;
			end
			if (free_out) begin
				result_valid <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free_s3 && valid_s2) begin
			prod_s3 <= PROD_W'(row_s2.dot) * scale_ext;
			bias_s3 <= row_s2.col_bias;
			dot_s3  <= row_s2.dot;
			clip_s3 <= row_s2.clip;
		end
		if (free_out && valid_s3) begin
			result.result_value <= total_sat;
			result.dot_sum      <= DOT_W'(dot_s3);
			result.saturated    <= clip_s3 | total_clip;
		end
	end

endmodule
